// ===== rtl/epe_pkg.sv =====
// Shared types and constants for the EVENODD parity encoder.
// Used by the decode, merge, top-level and checker modules; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package epe_pkg;

    // Fixed field widths of the channels and the config register
    localparam int OPCODE_W = 2;
    localparam int COLUMN_W = 5;
    localparam int ROW_W    = 4;
    localparam int OFFSET_W = 6;
    localparam int DATA_W   = 64;
    localparam int CFG_W    = 5;

    localparam int MIN_COLUMNS      = 3;
    localparam int DEF_MAX_COLUMNS  = 17;
    localparam int DEF_SYMBOL_WORDS = 64;
    localparam int DEF_WORD_BITS    = 64;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd5;

    typedef logic [OPCODE_W-1:0] opcode_t;

    localparam opcode_t OP_ACCUMULATE = 2'd0;
    localparam opcode_t OP_READ_ROW   = 2'd1;
    localparam opcode_t OP_READ_DIAG  = 2'd2;

    // Decoded item control, carried from decode into the update stage
    typedef struct packed {
        logic valid;
        logic is_acc;
        logic is_diag;
        logic first_row;
        logic first_diag;
    } dec_ctl_t;

    // Address matches against the write retiring in the same cycle as the read
    typedef struct packed {
        logic row;
        logic diag_a;
        logic diag_b;
    } fwd_hit_t;

endpackage

`default_nettype wire

// ===== rtl/epe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address collision. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module epe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/epe_decode.sv =====
// Item decode: effective column count, range checks, diagonal group and
// memory addresses. Depends on epe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module epe_decode #(
    parameter int MAX_COLUMNS  = 17,
    parameter int SYMBOL_WORDS = 64
) (
    input  wire logic [epe_pkg::CFG_W-1:0]    data_columns,
    input  wire epe_pkg::opcode_t             opcode,
    input  wire logic [epe_pkg::COLUMN_W-1:0] column,
    input  wire logic [epe_pkg::ROW_W-1:0]    row,
    input  wire logic [epe_pkg::OFFSET_W-1:0] word_offset,
    output epe_pkg::dec_ctl_t                 ctl,
    output logic [$clog2((MAX_COLUMNS-1)*SYMBOL_WORDS)-1:0] row_addr,
    output logic [$clog2(MAX_COLUMNS*SYMBOL_WORDS)-1:0]     diag_a_addr,
    output logic [$clog2(MAX_COLUMNS*SYMBOL_WORDS)-1:0]     diag_b_addr
);

    import epe_pkg::*;

    localparam int ROW_AW  = $clog2((MAX_COLUMNS-1)*SYMBOL_WORDS);
    localparam int DIAG_AW = $clog2(MAX_COLUMNS*SYMBOL_WORDS);

    logic [CFG_W-1:0] k_eff;
    logic [CFG_W-1:0] k_m1;
    logic [CFG_W:0]   sum;
    logic [CFG_W:0]   sum_red;
    logic [CFG_W-1:0] grp;
    logic [CFG_W-1:0] diag_sel;
    logic             row_ok;
    logic             off_ok;
    logic             col_ok;

    always_comb begin
        if (data_columns < CFG_W'(MIN_COLUMNS)) begin
            k_eff = CFG_W'(MIN_COLUMNS);
        end else if (int'(data_columns) > MAX_COLUMNS) begin
            k_eff = CFG_W'(MAX_COLUMNS);
        end else begin
            k_eff = data_columns;
        end
    end

    assign k_m1   = k_eff - CFG_W'(1);
    assign row_ok = CFG_W'(row) < k_m1;
    assign off_ok = int'(word_offset) < SYMBOL_WORDS;
    assign col_ok = column < k_eff;

    // column < k and row < k-1, so one conditional subtract gives the modulo
    assign sum     = (CFG_W+1)'(column) + (CFG_W+1)'(row);
    assign sum_red = (sum >= (CFG_W+1)'(k_eff)) ? sum - (CFG_W+1)'(k_eff) : sum;
    assign grp     = sum_red[CFG_W-1:0];

    always_comb begin
        ctl            = '0;
        ctl.is_acc     = (opcode == OP_ACCUMULATE);
        ctl.is_diag    = (opcode == OP_READ_DIAG);
        ctl.first_row  = (column == '0);
        // special group k-1 opens with column 1, last row
        if (grp == k_m1) begin
            ctl.first_diag = (column == COLUMN_W'(1)) && (CFG_W'(row) == k_m1 - CFG_W'(1));
        end else begin
            ctl.first_diag = (column == '0);
        end
        case (opcode)
            OP_ACCUMULATE: ctl.valid = row_ok && off_ok && col_ok;
            OP_READ_ROW:   ctl.valid = row_ok && off_ok;
            OP_READ_DIAG:  ctl.valid = row_ok && off_ok;
            default:       ctl.valid = 1'b0;
        endcase
    end

    assign diag_sel    = ctl.is_acc ? grp : CFG_W'(row);
    assign row_addr    = ROW_AW'(int'(row) * SYMBOL_WORDS + int'(word_offset));
    assign diag_a_addr = DIAG_AW'(int'(diag_sel) * SYMBOL_WORDS + int'(word_offset));
    assign diag_b_addr = DIAG_AW'(int'(k_m1) * SYMBOL_WORDS + int'(word_offset));

endmodule

`default_nettype wire

// ===== rtl/epe_merge.sv =====
// Update stage datapath: forwarding select, first-write or XOR fold, and
// read result. Depends on epe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module epe_merge #(
    parameter int WORD_BITS = 64
) (
    input  wire epe_pkg::dec_ctl_t    ctl,
    input  wire epe_pkg::fwd_hit_t    hit,
    input  wire logic [WORD_BITS-1:0] word,
    input  wire logic [WORD_BITS-1:0] row_rd,
    input  wire logic [WORD_BITS-1:0] diag_a_rd,
    input  wire logic [WORD_BITS-1:0] diag_b_rd,
    input  wire logic [WORD_BITS-1:0] fwd_row_data,
    input  wire logic [WORD_BITS-1:0] fwd_diag_data,
    output logic      [WORD_BITS-1:0] row_wdata,
    output logic      [WORD_BITS-1:0] diag_wdata,
    output logic      [WORD_BITS-1:0] rd_result
);

    import epe_pkg::*;

    logic [WORD_BITS-1:0] row_old;
    logic [WORD_BITS-1:0] diag_a_old;
    logic [WORD_BITS-1:0] diag_b_old;

    // memory read raced the previous item's write: take the written value
    assign row_old    = hit.row    ? fwd_row_data  : row_rd;
    assign diag_a_old = hit.diag_a ? fwd_diag_data : diag_a_rd;
    assign diag_b_old = hit.diag_b ? fwd_diag_data : diag_b_rd;

    assign row_wdata  = ctl.first_row  ? word : (row_old ^ word);
    assign diag_wdata = ctl.first_diag ? word : (diag_a_old ^ word);
    assign rd_result  = ctl.is_diag ? (diag_a_old ^ diag_b_old) : row_old;

endmodule

`default_nettype wire

// ===== rtl/evenodd_parity_encoder.sv =====
// EVENODD parity encoder top level: decode, parity memories, update stage
// and output register. Depends on epe_pkg, epe_decode, epe_merge, epe_ram.
//
// Input channel s_*: accumulate items fold a data word into its row parity
// and its diagonal group; read items ask for a row or diagonal parity word.
// Result channel m_*: one item per in-range read, none for accumulates or
// out-of-range items. Config: cfg_wr_en/cfg_wr_data set the column count k,
// which the user must write only while the block is idle; it is unchecked.
// Throughput: one item per cycle while s_ready is high, set by one
// read-modify-write per cycle on the row memory and both diagonal copies.
// A read passes through the update stage and then the output register.
// Back-to-back updates to one entry are covered by forwarding the value
// written in the same cycle as the next item's memory read.
// Reset clears the pipeline, the output register and k (back to 5); the
// parity memories are not cleared, so an entry must get its first
// contribution before it is folded again or read.
// Receiver stall: the output register holds its item and one more read may
// wait in the update stage; s_ready then drops until m_ready returns.
`timescale 1ns / 1ps
`default_nettype none

module evenodd_parity_encoder #(
    parameter int MAX_COLUMNS  = epe_pkg::DEF_MAX_COLUMNS,
    parameter int SYMBOL_WORDS = epe_pkg::DEF_SYMBOL_WORDS,
    parameter int WORD_BITS    = epe_pkg::DEF_WORD_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [epe_pkg::CFG_W-1:0]         cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire epe_pkg::opcode_t                  s_opcode,
    input  wire logic [epe_pkg::COLUMN_W-1:0]      s_column,
    input  wire logic [epe_pkg::ROW_W-1:0]         s_row,
    input  wire logic [epe_pkg::OFFSET_W-1:0]      s_word_offset,
    input  wire logic [epe_pkg::DATA_W-1:0]        s_data_word,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [epe_pkg::DATA_W-1:0]             m_parity_word,
    output logic [epe_pkg::ROW_W-1:0]              m_parity_row,
    output logic [epe_pkg::OFFSET_W-1:0]           m_parity_offset
);

    import epe_pkg::*;

    localparam int ROW_DEPTH  = (MAX_COLUMNS - 1) * SYMBOL_WORDS;
    localparam int DIAG_DEPTH = MAX_COLUMNS * SYMBOL_WORDS;
    localparam int ROW_AW     = $clog2(ROW_DEPTH);
    localparam int DIAG_AW    = $clog2(DIAG_DEPTH);

    logic [CFG_W-1:0]     cfg_reg;

    dec_ctl_t             dec_ctl;
    logic [ROW_AW-1:0]    dec_row_addr;
    logic [DIAG_AW-1:0]   dec_diag_a_addr;
    logic [DIAG_AW-1:0]   dec_diag_b_addr;

    logic                 accept;
    logic                 s1_adv;
    logic                 s1_wr;
    fwd_hit_t             hit_next;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    dec_ctl_t             s1_ctl_reg;
    fwd_hit_t             s1_hit_reg;
    logic [WORD_BITS-1:0] s1_word_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic [OFFSET_W-1:0]  s1_off_reg;
    logic [ROW_AW-1:0]    s1_row_addr_reg;
    logic [DIAG_AW-1:0]   s1_diag_addr_reg;
    logic [WORD_BITS-1:0] s1_fwd_row_data_reg;
    logic [WORD_BITS-1:0] s1_fwd_diag_data_reg;

    logic [WORD_BITS-1:0] row_rd;
    logic [WORD_BITS-1:0] diag_a_rd;
    logic [WORD_BITS-1:0] diag_b_rd;
    logic [WORD_BITS-1:0] row_wdata;
    logic [WORD_BITS-1:0] diag_wdata;
    logic [WORD_BITS-1:0] rd_result;

    logic                 load_out;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    logic [DATA_W-1:0]    m_parity_word_reg;
    logic [ROW_W-1:0]     m_parity_row_reg;
    logic [OFFSET_W-1:0]  m_parity_offset_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    epe_decode #(
        .MAX_COLUMNS  (MAX_COLUMNS),
        .SYMBOL_WORDS (SYMBOL_WORDS)
    ) u_decode (
        .data_columns (cfg_reg),
        .opcode       (s_opcode),
        .column       (s_column),
        .row          (s_row),
        .word_offset  (s_word_offset),
        .ctl          (dec_ctl),
        .row_addr     (dec_row_addr),
        .diag_a_addr  (dec_diag_a_addr),
        .diag_b_addr  (dec_diag_b_addr)
    );

    // Only a read waiting on a full output register holds the update stage
    assign s1_adv  = !s1_valid_reg || s1_ctl_reg.is_acc || !m_valid_reg || m_ready;
    assign s_ready = s1_adv;
    assign accept  = s_valid && s_ready;
    assign s1_wr   = s1_valid_reg && s1_ctl_reg.is_acc;

    assign hit_next.row    = s1_wr && (dec_row_addr == s1_row_addr_reg);
    assign hit_next.diag_a = s1_wr && (dec_diag_a_addr == s1_diag_addr_reg);
    assign hit_next.diag_b = s1_wr && (dec_diag_b_addr == s1_diag_addr_reg);

    assign s1_valid_next = s1_adv ? (accept && dec_ctl.valid) : s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg           <= dec_ctl;
            s1_hit_reg           <= hit_next;
            s1_word_reg          <= s_data_word[WORD_BITS-1:0];
            s1_row_reg           <= s_row;
            s1_off_reg           <= s_word_offset;
            s1_row_addr_reg      <= dec_row_addr;
            s1_diag_addr_reg     <= dec_diag_a_addr;
            s1_fwd_row_data_reg  <= row_wdata;
            s1_fwd_diag_data_reg <= diag_wdata;
        end
    end

    epe_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROW_DEPTH)
    ) u_row_ram (
        .clk     (aclk),
        .wr_en   (s1_wr),
        .wr_addr (s1_row_addr_reg),
        .wr_data (row_wdata),
        .rd_en   (accept),
        .rd_addr (dec_row_addr),
        .rd_data (row_rd)
    );

    // Two identical diagonal copies give the two reads a diagonal item needs
    epe_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DIAG_DEPTH)
    ) u_diag_ram_a (
        .clk     (aclk),
        .wr_en   (s1_wr),
        .wr_addr (s1_diag_addr_reg),
        .wr_data (diag_wdata),
        .rd_en   (accept),
        .rd_addr (dec_diag_a_addr),
        .rd_data (diag_a_rd)
    );

    epe_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DIAG_DEPTH)
    ) u_diag_ram_b (
        .clk     (aclk),
        .wr_en   (s1_wr),
        .wr_addr (s1_diag_addr_reg),
        .wr_data (diag_wdata),
        .rd_en   (accept),
        .rd_addr (dec_diag_b_addr),
        .rd_data (diag_b_rd)
    );

    epe_merge #(
        .WORD_BITS (WORD_BITS)
    ) u_merge (
        .ctl           (s1_ctl_reg),
        .hit           (s1_hit_reg),
        .word          (s1_word_reg),
        .row_rd        (row_rd),
        .diag_a_rd     (diag_a_rd),
        .diag_b_rd     (diag_b_rd),
        .fwd_row_data  (s1_fwd_row_data_reg),
        .fwd_diag_data (s1_fwd_diag_data_reg),
        .row_wdata     (row_wdata),
        .diag_wdata    (diag_wdata),
        .rd_result     (rd_result)
    );

    assign load_out     = s1_valid_reg && !s1_ctl_reg.is_acc && s1_adv;
    assign m_valid_next = load_out || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_parity_word_reg   <= DATA_W'(rd_result);
            m_parity_row_reg    <= s1_row_reg;
            m_parity_offset_reg <= s1_off_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_parity_word   = m_parity_word_reg;
    assign m_parity_row    = m_parity_row_reg;
    assign m_parity_offset = m_parity_offset_reg;

endmodule

`default_nettype wire

// ===== rtl/epe_checker.sv =====
// Port-level checks for the EVENODD parity encoder, bound to the top level.
// Depends on epe_pkg and evenodd_parity_encoder.
`timescale 1ns / 1ps
`default_nettype none

module epe_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire epe_pkg::opcode_t             s_opcode,
    input wire logic [epe_pkg::ROW_W-1:0]    s_row,
    input wire logic [epe_pkg::OFFSET_W-1:0] s_word_offset,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [epe_pkg::DATA_W-1:0]   m_parity_word,
    input wire logic [epe_pkg::ROW_W-1:0]    m_parity_row,
    input wire logic [epe_pkg::OFFSET_W-1:0] m_parity_offset
);

    import epe_pkg::*;

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_parity_word)
            && $stable(m_parity_row) && $stable(m_parity_offset))
        else $error("stalled result changed");

    // the input side only backs up behind a stalled output
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("s_ready low while output free");

    // row 0, offset 0 is always in range: its read comes out once the output register is free
    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == OP_READ_ROW && s_row == '0
            && s_word_offset == '0) ##1 (!m_valid || m_ready)
        |=> m_valid && m_parity_row == '0 && m_parity_offset == '0)
        else $error("read result missing or wrong echo");

endmodule

bind evenodd_parity_encoder epe_checker u_epe_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_opcode        (s_opcode),
    .s_row           (s_row),
    .s_word_offset   (s_word_offset),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_parity_word   (m_parity_word),
    .m_parity_row    (m_parity_row),
    .m_parity_offset (m_parity_offset)
);

`default_nettype wire

// ===== tb/evenodd_parity_encoder_test.sv =====
// Self-checking testbench for evenodd_parity_encoder: directed table, then random
// EVENODD stripes with reads and noise, checked against an in-bench parity model.
// Depends on epe_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module evenodd_parity_encoder_test;
    import epe_pkg::*;

    localparam int SYM_WORDS      = DEF_SYMBOL_WORDS;
    localparam int ROW_SLOTS      = (DEF_MAX_COLUMNS - 1) * SYM_WORDS;
    localparam int DIAG_SLOTS     = DEF_MAX_COLUMNS * SYM_WORDS;
    localparam int DIRECTED_N     = 23;
    localparam int NPHASES        = 11;
    localparam int PHASE_ITEMS    = 150;
    localparam int BURST_ITEMS    = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    localparam opcode_t          OP_UNUSED = 2'd3;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef enum {ITEM_IGNORED, ITEM_ACTIVE, ITEM_FORBIDDEN} item_class_t;

    typedef struct packed {
        opcode_t               op;
        logic [COLUMN_W-1:0]   col;
        logic [ROW_W-1:0]      row;
        logic [OFFSET_W-1:0]   off;
        logic [DATA_W-1:0]     data;
    } enc_req_t;

    typedef struct packed {
        logic [DATA_W-1:0]     word;
        logic [ROW_W-1:0]      row;
        logic [OFFSET_W-1:0]   off;
    } parity_item_t;

    typedef struct packed {
        opcode_t               op;
        logic [COLUMN_W-1:0]   col;
        logic [ROW_W-1:0]      row;
        logic [OFFSET_W-1:0]   off;
        logic [DATA_W-1:0]     data;
        logic                  typed;
        logic [DATA_W-1:0]     typed_word;
    } directed_row_t;

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_W-1:0]      cfg_wr_data   = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    opcode_t               s_opcode      = OP_ACCUMULATE;
    logic [COLUMN_W-1:0]   s_column      = '0;
    logic [ROW_W-1:0]      s_row         = '0;
    logic [OFFSET_W-1:0]   s_word_offset = '0;
    logic [DATA_W-1:0]     s_data_word   = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [DATA_W-1:0]     m_parity_word;
    logic [ROW_W-1:0]      m_parity_row;
    logic [OFFSET_W-1:0]   m_parity_offset;

    // parity model state; the written flags keep stimulus off undefined entries
    logic [DATA_W-1:0]     row_parity   [ROW_SLOTS];
    logic [DATA_W-1:0]     diag_parity  [DIAG_SLOTS];
    bit                    row_written  [ROW_SLOTS];
    bit                    diag_written [DIAG_SLOTS];
    logic [CFG_W-1:0]      cfg_k = CFG_RESET;

    parity_item_t          pending_parity[$];
    int                    mismatches   = 0;
    int                    quiet_cycles = 0;
    int                    send_quiet   = 0;
    int                    recv_quiet   = 0;
    bit                    burst_mode   = 1'b0;
    bit                    hold_output  = 1'b0;

    // k = 5 after reset
    directed_row_t directed_plan [DIRECTED_N] = '{
        '{OP_ACCUMULATE,  5'd0,  4'd0,  6'd0,  ALL_ONES,               1'b0, 64'd0},
        '{OP_READ_ROW,    5'd0,  4'd0,  6'd0,  64'd0,                  1'b1, ALL_ONES},
        '{OP_ACCUMULATE,  5'd0,  4'd1,  6'd0,  64'd0,                  1'b0, 64'd0},
        '{OP_READ_ROW,    5'd0,  4'd1,  6'd0,  ALL_ONES,               1'b1, 64'd0},
        '{OP_ACCUMULATE,  5'd0,  4'd2,  6'd0,  64'h8000_0000_0000_0001, 1'b0, 64'd0},
        '{OP_ACCUMULATE,  5'd0,  4'd3,  6'd0,  64'h5555_5555_5555_5555, 1'b0, 64'd0},
        // column 1, row k-2 opens the special group
        '{OP_ACCUMULATE,  5'd1,  4'd3,  6'd0,  64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0},
        '{OP_READ_DIAG,   5'd0,  4'd3,  6'd0,  64'd0,                  1'b1, ALL_ONES},
        '{OP_ACCUMULATE,  5'd1,  4'd0,  6'd0,  64'h0123_4567_89AB_CDEF, 1'b0, 64'd0},
        '{OP_ACCUMULATE,  5'd4,  4'd0,  6'd0,  64'hFEDC_BA98_7654_3210, 1'b0, 64'd0},
        '{OP_ACCUMULATE,  5'd5,  4'd0,  6'd0,  ALL_ONES,               1'b0, 64'd0},
        '{OP_ACCUMULATE,  5'd0,  4'd4,  6'd0,  ALL_ONES,               1'b0, 64'd0},
        '{OP_READ_ROW,    5'd0,  4'd4,  6'd0,  64'd0,                  1'b0, 64'd0},
        '{OP_UNUSED,      5'd0,  4'd0,  6'd0,  64'd0,                  1'b0, 64'd0},
        '{OP_READ_ROW,    5'd0,  4'd0,  6'd0,  64'd0,                  1'b0, 64'd0},
        '{OP_READ_DIAG,   5'd0,  4'd0,  6'd0,  64'd0,                  1'b0, 64'd0},
        '{OP_READ_DIAG,   5'd0,  4'd1,  6'd0,  64'd0,                  1'b0, 64'd0},
        '{OP_ACCUMULATE,  5'd0,  4'd3,  6'd63, ALL_ONES,               1'b0, 64'd0},
        '{OP_READ_ROW,    5'd0,  4'd3,  6'd63, 64'd0,                  1'b1, ALL_ONES},
        '{OP_ACCUMULATE,  5'd31, 4'd15, 6'd63, ALL_ONES,               1'b0, 64'd0},
        '{OP_READ_DIAG,   5'd0,  4'd15, 6'd63, 64'd0,                  1'b0, 64'd0},
        '{OP_UNUSED,      5'd31, 4'd15, 6'd63, ALL_ONES,               1'b0, 64'd0},
        '{OP_READ_ROW,    5'd0,  4'd2,  6'd0,  64'd0,                  1'b1, 64'h8000_0000_0000_0001}
    };

    logic [CFG_W-1:0] column_plan [NPHASES] = '{
        5'd17, 5'd3, 5'd0, 5'd31, 5'd7, 5'd9, 5'd13, 5'd2, 5'd11, 5'd17, 5'd5
    };

    evenodd_parity_encoder DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_column        (s_column),
        .s_row           (s_row),
        .s_word_offset   (s_word_offset),
        .s_data_word     (s_data_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_parity_word   (m_parity_word),
        .m_parity_row    (m_parity_row),
        .m_parity_offset (m_parity_offset)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned column_count();
        if (cfg_k < CFG_W'(MIN_COLUMNS)) return MIN_COLUMNS;
        if (int'(cfg_k) > DEF_MAX_COLUMNS) return DEF_MAX_COLUMNS;
        return int'(cfg_k);
    endfunction

    // slot of the diagonal group an accumulate lands in, and whether it opens it
    function automatic int unsigned diag_slot(input enc_req_t q, input int unsigned k,
                                              output bit first);
        int unsigned grp;
        grp = (q.col + q.row) % k;
        if (grp == k - 1) first = (q.col == 1) && (q.row == k - 2);
        else first = (q.col == 0);
        return grp * SYM_WORDS + q.off;
    endfunction

    function automatic item_class_t classify(input enc_req_t q);
        int unsigned k, rs, ds;
        bit first;
        k = column_count();
        if (q.row >= k - 1) return ITEM_IGNORED;
        rs = q.row * SYM_WORDS + q.off;
        case (q.op)
            OP_ACCUMULATE: begin
                if (q.col >= k) return ITEM_IGNORED;
                ds = diag_slot(q, k, first);
                if ((q.col != 0 && !row_written[rs]) || (!first && !diag_written[ds]))
                    return ITEM_FORBIDDEN;
                return ITEM_ACTIVE;
            end
            OP_READ_ROW: return row_written[rs] ? ITEM_ACTIVE : ITEM_FORBIDDEN;
            OP_READ_DIAG: begin
                if (diag_written[q.row * SYM_WORDS + q.off]
                    && diag_written[(k - 1) * SYM_WORDS + q.off])
                    return ITEM_ACTIVE;
                return ITEM_FORBIDDEN;
            end
            default: return ITEM_IGNORED;
        endcase
    endfunction

    // folds an accumulate into the parity store, or returns the parity a read asks for
    function automatic bit fold_parity(input enc_req_t q, output parity_item_t res);
        int unsigned k, rs, ds;
        bit first;
        k = column_count();
        res = '0;
        if (q.row >= k - 1) return 1'b0;
        rs = q.row * SYM_WORDS + q.off;
        case (q.op)
            OP_ACCUMULATE: begin
                if (q.col >= k) return 1'b0;
                row_parity[rs]  = (q.col == 0) ? q.data : row_parity[rs] ^ q.data;
                row_written[rs] = 1'b1;
                ds = diag_slot(q, k, first);
                diag_parity[ds]  = first ? q.data : diag_parity[ds] ^ q.data;
                diag_written[ds] = 1'b1;
                return 1'b0;
            end
            OP_READ_ROW: res.word = row_parity[rs];
            OP_READ_DIAG: res.word = diag_parity[q.row * SYM_WORDS + q.off]
                                     ^ diag_parity[(k - 1) * SYM_WORDS + q.off];
            default: return 1'b0;
        endcase
        res.row = q.row;
        res.off = q.off;
        return 1'b1;
    endfunction

    function automatic int pick_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic enc_req_t noise_item();
        enc_req_t q;
        q.op   = opcode_t'($urandom_range(0, 3));
        q.col  = COLUMN_W'($urandom_range(0, 31));
        q.row  = ROW_W'($urandom_range(0, 15));
        q.off  = OFFSET_W'($urandom_range(0, 63));
        q.data = random_word();
        return q;
    endfunction

    function automatic enc_req_t pick_read(input logic [OFFSET_W-1:0] off);
        enc_req_t q;
        int unsigned k;
        k = column_count();
        q.op   = $urandom_range(0, 1) ? OP_READ_ROW : OP_READ_DIAG;
        q.col  = COLUMN_W'($urandom_range(0, 31));
        q.row  = ROW_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(0, k - 2));
        q.off  = ($urandom_range(0, 3) == 0) ? OFFSET_W'($urandom_range(0, 63)) : off;
        q.data = random_word();
        return q;
    endfunction

    task automatic offer_item(input enc_req_t q, input bit typed,
                              input logic [DATA_W-1:0] typed_word);
        int gap;
        parity_item_t res;
        gap = burst_mode ? 0 : pick_wait(send_quiet);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= q.op;
        s_column      <= q.col;
        s_row         <= q.row;
        s_word_offset <= q.off;
        s_data_word   <= q.data;
        do @(posedge aclk); while (!s_ready);
        if (fold_parity(q, res)) begin
            if (typed) res.word = typed_word;
            pending_parity.insert(pending_parity.size(), res);
        end
    endtask

    task automatic try_item(input enc_req_t q, inout int done);
        item_class_t c;
        c = classify(q);
        if (c == ITEM_FORBIDDEN) return;
        offer_item(q, 1'b0, '0);
        if (c == ITEM_ACTIVE) done++;
    endtask

    // stripes go column by column so every entry is opened before it is folded
    task automatic run_stripes(input int budget);
        int done, k, c, r, rot;
        logic [OFFSET_W-1:0] off;
        enc_req_t q;
        done = 0;
        k = int'(column_count());
        while (done < budget) begin
            off = OFFSET_W'($urandom_range(0, 63));
            rot = int'($urandom_range(0, k - 2));
            for (c = 0; c < k && done < budget; c++) begin
                for (r = 0; r < k - 1 && done < budget; r++) begin
                    q.op   = OP_ACCUMULATE;
                    q.col  = COLUMN_W'(c);
                    q.row  = ROW_W'((r + rot) % (k - 1));
                    q.off  = off;
                    q.data = random_word();
                    try_item(q, done);
                    if ($urandom_range(0, 2) == 0) try_item(pick_read(off), done);
                    if ($urandom_range(0, 9) == 0) try_item(noise_item(), done);
                end
            end
        end
    endtask

    task automatic set_columns(input logic [CFG_W-1:0] value);
        s_valid <= 1'b0;
        while (pending_parity.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        cfg_k = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // back-to-back reads while the result side is held off
    task automatic squeeze_output();
        int done, tries;
        enc_req_t q;
        done = 0;
        hold_output = 1'b1;
        burst_mode  = 1'b1;
        for (tries = 0; done < BURST_ITEMS && tries < 5000; tries++) begin
            q = pick_read(OFFSET_W'($urandom_range(0, 63)));
            if (classify(q) == ITEM_ACTIVE) begin
                offer_item(q, 1'b0, '0);
                done++;
            end
        end
        burst_mode = 1'b0;
    endtask

    initial begin
        int i, p;
        enc_req_t q;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        for (i = 0; i < DIRECTED_N; i++) begin
            q.op   = directed_plan[i].op;
            q.col  = directed_plan[i].col;
            q.row  = directed_plan[i].row;
            q.off  = directed_plan[i].off;
            q.data = directed_plan[i].data;
            offer_item(q, directed_plan[i].typed, directed_plan[i].typed_word);
        end
        for (p = 0; p < NPHASES; p++) begin
            set_columns(column_plan[p]);
            if (p == 2) squeeze_output();
            run_stripes(PHASE_ITEMS);
        end
        s_valid <= 1'b0;
        while (pending_parity.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) $display("evenodd_parity_encoder_test: clean");
        else $display("evenodd_parity_encoder_test: errors");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = 0;
            if (hold_output) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_output = 1'b0;
            end else begin
                stall = pick_wait(recv_quiet);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    always @(posedge aclk) begin : check_results
        parity_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_parity.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected item: word %h row %0d offset %0d",
                             m_parity_word, m_parity_row, m_parity_offset);
            end else begin
                want = pending_parity.pop_front();
                if (m_parity_word !== want.word || m_parity_row !== want.row
                    || m_parity_offset !== want.off) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected word %h row %0d offset %0d, got %h %0d %0d",
                                 want.word, want.row, want.off,
                                 m_parity_word, m_parity_row, m_parity_offset);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("evenodd_parity_encoder_test: errors");
                $finish;
            end
        end
    end

endmodule

// ===== files.f =====
rtl/epe_pkg.sv
rtl/epe_ram.sv
rtl/epe_decode.sv
rtl/epe_merge.sv
rtl/evenodd_parity_encoder.sv
rtl/epe_checker.sv
tb/evenodd_parity_encoder_test.sv
